// ----- hw/rtl/bpjt_pkg.sv -----
// shared types and constants for the bounded priority job table
`timescale 1ns / 1ps
`default_nettype none
package bpjt_pkg;
	localparam int Depth = 8;
	localparam int IdxW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [8:0] PrioMax = 9'd256;
	localparam logic [8:0] PrioNone = 9'd257;
	localparam logic [6:0] MaxResults = 7'd8;

	typedef enum logic [2:0] {
		ACT_SUBMIT = 3'd0,
		ACT_CLEAR  = 3'd1,
		ACT_REMOVE = 3'd2,
		ACT_LIST   = 3'd3,
		ACT_CHANGE = 3'd4,
		ACT_COUNT  = 3'd5,
		ACT_TAKE   = 3'd6,
		ACT_NOP    = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_SHIFT,
		FSM_LIST,
		FSM_DONE
	} fsm_t;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  jtype;
		logic [8:0]  prio;
	} entry_t;
endpackage
`default_nettype wire

// ----- hw/rtl/bounded_priority_job_table_unit.sv -----
// top level of the bounded priority job table
//
// command channel: an item is taken when start is high and busy is low;
// busy stays high until the last result of that item has been shown.
// result channel: each result is on the ports for one cycle with strobe
// high; last marks the final one. the receiver cannot stall it.
// jobs sit in one entry memory with a registered read; list, remove,
// change and take walk its single read port, one entry per cycle while
// they scan or list. submit, clear, count and the first list result show
// in the cycle after the item is taken; further list results follow one
// per cycle. remove and change scan up to the match, or the whole table
// when none matches; take always scans the whole table. remove and take
// then close the gap by moving each later entry down one place, reading
// each entry before writing it back.
// a new item can be taken in the cycle after the last result; how long an
// item holds the unit is set by the single memory read port.
// reset empties the table and restarts the id counter at zero, so the
// first id given is one; memory contents are not cleared, since entries
// at or above the count are never read.
`timescale 1ns / 1ps
`default_nettype none
module bounded_priority_job_table_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  action,
	input  wire logic [15:0] job_id,
	input  wire logic [8:0]  priority_req,
	input  wire logic [7:0]  job_kind,
	input  wire logic [6:0]  list_limit,
	output logic             strobe,
	output logic [1:0]       status,
	output logic [15:0]      out_id,
	output logic [7:0]       out_type,
	output logic [8:0]       out_priority,
	output logic [6:0]       job_count,
	output logic             last
);
	localparam int IW = bpjt_pkg::IdxW;
	localparam int CW = bpjt_pkg::CntW;

	bpjt_pkg::fsm_t state_q, state_d;
	bpjt_pkg::action_t act_q;
	logic [15:0] id_q, next_id_q;
	logic [8:0] prio_q;
	logic [7:0] type_q;
	logic [CW-1:0] occ_q, n_q, idx_q, pos_q;
	logic found_q;
	bpjt_pkg::entry_t best_q;
	logic [8:0] minp_q;
	logic rd_vld_s1;
	logic [CW-1:0] rd_idx_s1;

	logic we;
	logic [IW-1:0] waddr, raddr;
	bpjt_pkg::entry_t wdata, rdata;

	bpjt_mem u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [8:0] prio_in;
	assign prio_in = (priority_req > bpjt_pkg::PrioMax) ? bpjt_pkg::PrioMax : priority_req;
	logic accept;
	assign accept = start && !busy;
	assign busy = (state_q != bpjt_pkg::FSM_IDLE);

	logic [6:0] list_n;
	always_comb begin
		list_n = (list_limit < 7'(occ_q)) ? list_limit : 7'(occ_q);
		if (list_n > bpjt_pkg::MaxResults) begin
			list_n = bpjt_pkg::MaxResults;
		end
	end

	// scan issues reads at idx; data returns in the next cycle, tagged rd_idx_s1
	logic scan_done;
	assign scan_done = !rd_vld_s1 && (idx_q >= occ_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bpjt_pkg::FSM_IDLE: begin
				if (accept) begin
					case (bpjt_pkg::action_t'(action))
						bpjt_pkg::ACT_REMOVE, bpjt_pkg::ACT_CHANGE, bpjt_pkg::ACT_TAKE:
							state_d = bpjt_pkg::FSM_SCAN;
						bpjt_pkg::ACT_LIST:
							state_d = (list_n == 7'd0) ? bpjt_pkg::FSM_DONE : bpjt_pkg::FSM_LIST;
						default: state_d = bpjt_pkg::FSM_DONE;
					endcase
				end
			end
			bpjt_pkg::FSM_SCAN: begin
				if (scan_done || (act_q != bpjt_pkg::ACT_TAKE && found_q)) begin
					if ((found_q || (act_q == bpjt_pkg::ACT_TAKE && occ_q != '0))
					    && act_q != bpjt_pkg::ACT_CHANGE) begin
						state_d = bpjt_pkg::FSM_SHIFT;
					end else begin
						state_d = bpjt_pkg::FSM_DONE;
					end
				end
			end
			bpjt_pkg::FSM_SHIFT: begin
				if (!rd_vld_s1 && (idx_q + CW'(1) >= occ_q)) begin
					state_d = bpjt_pkg::FSM_DONE;
				end
			end
			bpjt_pkg::FSM_LIST: begin
				if (rd_vld_s1 && (rd_idx_s1 + CW'(1) == n_q)) begin
					state_d = bpjt_pkg::FSM_IDLE;
				end
			end
			bpjt_pkg::FSM_DONE: state_d = bpjt_pkg::FSM_IDLE;
			default: state_d = bpjt_pkg::FSM_IDLE;
		endcase
	end

	// memory port control
	logic issue;
	always_comb begin
		we = 1'b0;
		waddr = IW'(occ_q);
		wdata = '{id: next_id_q + 16'd1, jtype: job_kind, prio: prio_in};
		issue = 1'b0;
		raddr = idx_q[IW-1:0];
		case (state_q)
			bpjt_pkg::FSM_IDLE: begin
				if (accept && bpjt_pkg::action_t'(action) == bpjt_pkg::ACT_SUBMIT
				    && occ_q < CW'(bpjt_pkg::Depth)) begin
					we = 1'b1;
				end
				raddr = '0;
				// an empty table is never read
				issue = accept && (bpjt_pkg::action_t'(action) != bpjt_pkg::ACT_SUBMIT)
					&& (occ_q != '0);
			end
			bpjt_pkg::FSM_SCAN: begin
				issue = (idx_q < occ_q) && !found_q;
			end
			bpjt_pkg::FSM_SHIFT: begin
				// read idx+1 then write it back at idx
				raddr = IW'(idx_q + CW'(1));
				issue = !rd_vld_s1 && (idx_q + CW'(1) < occ_q);
				we = rd_vld_s1;
				waddr = IW'(idx_q);
				wdata = rdata;
			end
			bpjt_pkg::FSM_LIST: begin
				issue = (idx_q < n_q);
			end
			bpjt_pkg::FSM_DONE: begin
				if (act_q == bpjt_pkg::ACT_CHANGE && found_q) begin
					we = 1'b1;
					waddr = IW'(pos_q);
					wdata = '{id: best_q.id, jtype: best_q.jtype, prio: prio_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpjt_pkg::FSM_IDLE;
			occ_q <= '0;
			next_id_q <= '0;
			rd_vld_s1 <= 1'b0;
			found_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			rd_vld_s1 <= issue && (state_q != bpjt_pkg::FSM_SHIFT || !rd_vld_s1);
			rd_idx_s1 <= (state_q == bpjt_pkg::FSM_IDLE) ? '0 : idx_q;
			case (state_q)
				bpjt_pkg::FSM_IDLE: begin
					if (accept) begin
						act_q <= bpjt_pkg::action_t'(action);
						id_q <= job_id;
						prio_q <= prio_in;
						type_q <= job_kind;
						n_q <= CW'(list_n);
						// a submit that finds the table full is flagged here
						found_q <= (bpjt_pkg::action_t'(action) == bpjt_pkg::ACT_SUBMIT) && !we;
						minp_q <= bpjt_pkg::PrioNone;
						best_q <= '0;
						idx_q <= issue ? CW'(1) : '0;
						if (we) begin
							occ_q <= occ_q + CW'(1);
							next_id_q <= next_id_q + 16'd1;
						end
						if (bpjt_pkg::action_t'(action) == bpjt_pkg::ACT_CLEAR) begin
							occ_q <= '0;
						end
					end
				end
				bpjt_pkg::FSM_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (rd_vld_s1 && !found_q) begin
						if (act_q == bpjt_pkg::ACT_TAKE) begin
							if (rdata.prio < minp_q) begin
								minp_q <= rdata.prio;
								best_q <= rdata;
								pos_q <= rd_idx_s1;
							end
						end else if (rdata.id == id_q) begin
							found_q <= 1'b1;
							best_q <= rdata;
							pos_q <= rd_idx_s1;
						end
					end
					if (state_d != bpjt_pkg::FSM_SCAN) begin
						if (act_q == bpjt_pkg::ACT_TAKE) begin
							found_q <= (occ_q != '0);
							idx_q <= pos_q;
						end else begin
							idx_q <= pos_q;
						end
					end
				end
				bpjt_pkg::FSM_SHIFT: begin
					if (rd_vld_s1) begin
						idx_q <= idx_q + CW'(1);
					end
					if (state_d == bpjt_pkg::FSM_DONE) begin
						occ_q <= occ_q - CW'(1);
					end
				end
				bpjt_pkg::FSM_LIST: begin
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// result outputs
	always_comb begin
		strobe = 1'b0;
		status = bpjt_pkg::ST_OK;
		out_id = '0;
		out_type = '0;
		out_priority = '0;
		job_count = 7'(occ_q);
		last = 1'b1;
		case (state_q)
			bpjt_pkg::FSM_LIST: begin
				strobe = rd_vld_s1;
				out_id = rdata.id;
				out_type = rdata.jtype;
				out_priority = rdata.prio;
				last = (rd_idx_s1 + CW'(1) == n_q);
			end
			bpjt_pkg::FSM_DONE: begin
				strobe = 1'b1;
				case (act_q)
					bpjt_pkg::ACT_SUBMIT: begin
						// a real append shows up as the id just consumed
						if (found_q) begin
							status = bpjt_pkg::ST_FULL;
						end else begin
							out_id = next_id_q;
							out_type = type_q;
							out_priority = prio_q;
						end
					end
					bpjt_pkg::ACT_REMOVE: begin
						if (found_q) begin
							out_id = id_q;
						end else begin
							status = bpjt_pkg::ST_NOTFOUND;
						end
					end
					bpjt_pkg::ACT_CHANGE: begin
						if (found_q) begin
							out_id = best_q.id;
							out_type = best_q.jtype;
							out_priority = prio_q;
						end else begin
							status = bpjt_pkg::ST_NOTFOUND;
						end
					end
					bpjt_pkg::ACT_TAKE: begin
						if (found_q) begin
							out_id = best_q.id;
							out_type = best_q.jtype;
							out_priority = best_q.prio;
						end else begin
							status = bpjt_pkg::ST_EMPTY;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(bpjt_pkg::Depth)) else $error("count above depth");
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result outside an action");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !busy) else $error("busy after last result");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/bpjt_mem.sv -----
// entry memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module bpjt_mem (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [bpjt_pkg::IdxW-1:0] waddr,
	input  wire bpjt_pkg::entry_t          wdata,
	input  wire logic [bpjt_pkg::IdxW-1:0] raddr,
	output bpjt_pkg::entry_t               rdata
);
	bpjt_pkg::entry_t mem [bpjt_pkg::Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
